// ===== src/bilinear_crop_scaler_defines.svh =====
// ----------------------------------------------------------------------------
// bilinear crop scaler assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BILINEAR_CROP_SCALER_DEFINES_SVH
`define BILINEAR_CROP_SCALER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg
// word types, register map and state codes of the bilinear crop scaler
// ----------------------------------------------------------------------------
package bcs_pkg;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // divisor width: twice the widest output size
  localparam int DEN_W = 13;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH = 3'd0,
    REG_CROP_LEFT    = 3'd1,
    REG_CROP_TOP     = 3'd2,
    REG_CROP_WIDTH   = 3'd3,
    REG_CROP_HEIGHT  = 3'd4,
    REG_OUT_WIDTH    = 3'd5,
    REG_OUT_HEIGHT   = 3'd6,
    REG_GAIN         = 3'd7
  } cfg_reg_e;

  localparam logic [11:0] RST_SOURCE_WIDTH = 12'd2048;
  localparam logic [10:0] RST_CROP_LEFT    = 11'd0;
  localparam logic [9:0]  RST_CROP_TOP     = 10'd0;
  localparam logic [11:0] RST_CROP_WIDTH   = 12'd1;
  localparam logic [10:0] RST_CROP_HEIGHT  = 11'd1;
  localparam logic [11:0] RST_OUT_WIDTH    = 12'd1;
  localparam logic [10:0] RST_OUT_HEIGHT   = 11'd1;
  localparam logic [9:0]  RST_GAIN         = 10'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_RD,
    ST_WAIT,
    ST_H,
    ST_V,
    ST_G,
    ST_OUT
  } bcs_state_e;

  typedef struct packed {
    logic        cmd;
    logic [10:0] load_col;
    logic [9:0]  load_row;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [7:0]  in_alpha;
    logic [10:0] want_col;
    logic [9:0]  want_row;
  } bcs_in_t;

  typedef struct packed {
    logic [10:0] out_col;
    logic [9:0]  out_row;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
  } bcs_out_t;

endpackage

// ===== src/bcs_div.sv =====
// ----------------------------------------------------------------------------
// bcs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bcs_div import bcs_pkg::*; #(
  parameter int NUM_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== src/bilinear_crop_scaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_crop_scaler
// rgba image store with bilinear crop-and-scale sampling and colour gain
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_stall_o    in_word_i  (bcs_in_t)
//   out      out  out_valid_o / out_stall_i  out_word_o (bcs_out_t)
//   cfg      in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// a load word is written into the image memory at accept if it lies inside the store
// a sample word makes two passes of the bit-serial divider, four reads on
//   the image memory port and three steps per channel on the shared blend
//   multipliers
// reset clears the fsm, the row count and the registers; the image memory
//   is not cleared and holds garbage until written
// a stalled result sits in the output register while the next word is taken
//
module bilinear_crop_scaler import bcs_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 2048,
  parameter int MAX_SRC_HEIGHT = 1024,
  parameter int FRAC_BITS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bcs_in_t     in_word_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bcs_out_t    out_word_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_W  = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W  = $clog2(MAX_SRC_HEIGHT);
  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WU_W   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int HU_W   = $clog2(MAX_SRC_HEIGHT + 1);
  // numerator: (2*dest+1) * span, 12 x 12 bits, scaled by the fraction
  localparam int NUM_W  = 24 + FRAC_BITS;
  localparam int P_W    = NUM_W + 2;
  localparam int IP_W   = P_W - FRAC_BITS;
  localparam int ONE    = 1 << FRAC_BITS;
  localparam int HALF   = ONE / 2;
  localparam int FR_W   = FRAC_BITS + 1;
  localparam int TOP_W  = 8 + FRAC_BITS;
  localparam int BL_W   = 8 + 2 * FRAC_BITS;
  localparam int GN_W   = BL_W + 10;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [11:0] source_width_q;
  logic [10:0] crop_left_q;
  logic [9:0]  crop_top_q;
  logic [11:0] crop_width_q;
  logic [10:0] crop_height_q;
  logic [11:0] out_width_q;
  logic [10:0] out_height_q;
  logic [9:0]  gain_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_width_q <= RST_SOURCE_WIDTH;
      crop_left_q    <= RST_CROP_LEFT;
      crop_top_q     <= RST_CROP_TOP;
      crop_width_q   <= RST_CROP_WIDTH;
      crop_height_q  <= RST_CROP_HEIGHT;
      out_width_q    <= RST_OUT_WIDTH;
      out_height_q   <= RST_OUT_HEIGHT;
      gain_q         <= RST_GAIN;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_SOURCE_WIDTH: source_width_q <= pwdata[11:0];
        REG_CROP_LEFT:    crop_left_q    <= pwdata[10:0];
        REG_CROP_TOP:     crop_top_q     <= pwdata[9:0];
        REG_CROP_WIDTH:   crop_width_q   <= pwdata[11:0];
        REG_CROP_HEIGHT:  crop_height_q  <= pwdata[10:0];
        REG_OUT_WIDTH:    out_width_q    <= pwdata[11:0];
        REG_OUT_HEIGHT:   out_height_q   <= pwdata[10:0];
        REG_GAIN:         gain_q         <= pwdata[9:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_SOURCE_WIDTH: prdata = 32'(source_width_q);
      REG_CROP_LEFT:    prdata = 32'(crop_left_q);
      REG_CROP_TOP:     prdata = 32'(crop_top_q);
      REG_CROP_WIDTH:   prdata = 32'(crop_width_q);
      REG_CROP_HEIGHT:  prdata = 32'(crop_height_q);
      REG_OUT_WIDTH:    prdata = 32'(out_width_q);
      REG_OUT_HEIGHT:   prdata = 32'(out_height_q);
      REG_GAIN:         prdata = 32'(gain_q);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  bcs_state_e state_q, state_d;

  logic       in_acc;
  logic       is_load;
  logic       load_ok;
  logic       div_start;
  logic       div_sel_row;
  logic       div_done;
  logic       mem_re;
  logic       out_load;
  logic [1:0] rd_cnt_q;
  logic [1:0] ch_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign is_load = in_word_i.cmd == CMD_LOAD;
  // loads outside the store are dropped entirely
  assign load_ok = in_acc && is_load &&
                   (32'(in_word_i.load_col) < 32'(MAX_SRC_WIDTH)) &&
                   (32'(in_word_i.load_row) < 32'(MAX_SRC_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc && !is_load) state_d = ST_START;
      ST_START:   state_d = ST_DIV_COL;
      ST_DIV_COL: if (div_done) state_d = ST_DIV_ROW;
      ST_DIV_ROW: if (div_done) state_d = ST_RD;
      ST_RD:      if (rd_cnt_q == 2'd3) state_d = ST_WAIT;
      ST_WAIT:    state_d = ST_H;
      ST_H:       state_d = ST_V;
      ST_V:       state_d = ST_G;
      ST_G:       state_d = (ch_q == 2'd3) ? ST_OUT : ST_H;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall_o  = state_q != ST_IDLE;
    // column pass starts from ST_START, row pass right as the column one ends
    div_start   = (state_q == ST_START) || (state_q == ST_DIV_COL && div_done);
    div_sel_row = state_q == ST_DIV_COL;
    mem_re      = state_q == ST_RD;
    out_load    = (state_q == ST_OUT) && (!out_valid_o || !out_stall_i);
  end

  // --------------------------------------------------------------------------
  // row count and used source size
  // --------------------------------------------------------------------------
  logic [10:0]     rows_loaded_q;
  logic [WU_W-1:0] wid_used;
  logic [HU_W-1:0] hgt_used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_loaded_q <= '0;
    end else if (load_ok && ({1'b0, in_word_i.load_row} + 11'd1 > rows_loaded_q)) begin
      rows_loaded_q <= {1'b0, in_word_i.load_row} + 11'd1;
    end
  end

  // saturate to 1..max
  always_comb begin
    priority if (source_width_q == '0) begin
      wid_used = WU_W'(1);
    end else if (32'(source_width_q) > 32'(MAX_SRC_WIDTH)) begin
      wid_used = WU_W'(MAX_SRC_WIDTH);
    end else begin
      wid_used = WU_W'(source_width_q);
    end
    priority if (rows_loaded_q == '0) begin
      hgt_used = HU_W'(1);
    end else if (32'(rows_loaded_q) > 32'(MAX_SRC_HEIGHT)) begin
      hgt_used = HU_W'(MAX_SRC_HEIGHT);
    end else begin
      hgt_used = HU_W'(rows_loaded_q);
    end
  end

  // --------------------------------------------------------------------------
  // position mapping: q = (2*dest+1)*span*one / (2*size)
  // --------------------------------------------------------------------------
  logic [10:0]      want_col_q;
  logic [9:0]       want_row_q;
  logic [NUM_W-1:0] num_col_q;
  logic [NUM_W-1:0] num_row_q;
  logic [DEN_W-1:0] den_col;
  logic [DEN_W-1:0] den_row;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;

  // zero output size acts as one
  assign den_col = (out_width_q == '0)  ? DEN_W'(2) : {out_width_q, 1'b0};
  assign den_row = (out_height_q == '0) ? DEN_W'(2) : DEN_W'({out_height_q, 1'b0});

  always_ff @(posedge clk_i) begin
    if (in_acc && !is_load) begin
      want_col_q <= in_word_i.want_col;
      want_row_q <= in_word_i.want_row;
      num_col_q  <= (NUM_W'({in_word_i.want_col, 1'b1}) * NUM_W'(crop_width_q))
                    << FRAC_BITS;
      num_row_q  <= (NUM_W'({in_word_i.want_row, 1'b1}) * NUM_W'(crop_height_q))
                    << FRAC_BITS;
    end
  end

  assign div_num = div_sel_row ? num_row_q : num_col_q;
  assign div_den = div_sel_row ? den_row : den_col;

  bcs_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // pos+1 = origin + q + 1/2; fraction taken before the floor is clamped
  logic                 map_row;
  logic [P_W-1:0]       map_p;
  logic [IP_W-1:0]      map_ip;
  logic [IP_W-1:0]      map_lim;
  logic [IP_W-1:0]      map_lo;
  logic [IP_W-1:0]      map_hi;
  logic [FRAC_BITS-1:0] map_frac;

  assign map_row = state_q == ST_DIV_ROW;

  always_comb begin
    map_lim  = map_row ? IP_W'(hgt_used) : IP_W'(wid_used);
    map_p    = ((map_row ? P_W'(crop_top_q) : P_W'(crop_left_q)) << FRAC_BITS) +
               P_W'(div_quot) + P_W'(HALF);
    map_ip   = map_p[P_W-1:FRAC_BITS];
    map_frac = map_p[FRAC_BITS-1:0];
    // negative positions clamp to the first pixel
    map_lo   = (map_ip == '0) ? '0 : map_ip - 1'b1;
    if (map_lo > map_lim - 1'b1) begin
      map_lo = map_lim - 1'b1;
    end
    map_hi   = (map_lo == map_lim - 1'b1) ? map_lo : map_lo + 1'b1;
  end

  logic [COL_W-1:0]     col_lo_q, col_hi_q;
  logic [ROW_W-1:0]     row_lo_q, row_hi_q;
  logic [FRAC_BITS-1:0] frac_c_q, frac_r_q;

  always_ff @(posedge clk_i) begin
    if (div_done && state_q == ST_DIV_COL) begin
      col_lo_q <= COL_W'(map_lo);
      col_hi_q <= COL_W'(map_hi);
      frac_c_q <= map_frac;
    end
    if (div_done && state_q == ST_DIV_ROW) begin
      row_lo_q <= ROW_W'(map_lo);
      row_hi_q <= ROW_W'(map_hi);
      frac_r_q <= map_frac;
    end
  end

  // --------------------------------------------------------------------------
  // image memory: one write port for loads, one read port for neighbours
  // --------------------------------------------------------------------------
  logic [31:0]       pix_mem_q [DEPTH];
  logic [31:0]       mem_rdata_q;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [31:0]       mem_wdata;
  logic              rd_vld_q;
  logic [1:0]        rd_tag_q;
  logic [31:0]       pix_q [4];

  assign mem_waddr = ADDR_W'(in_word_i.load_row) * ADDR_W'(MAX_SRC_WIDTH) +
                     ADDR_W'(in_word_i.load_col);
  assign mem_wdata = {in_word_i.in_alpha, in_word_i.in_blue,
                      in_word_i.in_green, in_word_i.in_red};
  // read order: top-left, top-right, bottom-left, bottom-right
  assign mem_raddr = ADDR_W'(rd_cnt_q[1] ? row_hi_q : row_lo_q) * ADDR_W'(MAX_SRC_WIDTH) +
                     ADDR_W'(rd_cnt_q[0] ? col_hi_q : col_lo_q);

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      pix_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= pix_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
      rd_tag_q <= '0;
    end else begin
      rd_vld_q <= mem_re;
      rd_tag_q <= rd_cnt_q;
      if (mem_re) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      pix_q[rd_tag_q] <= mem_rdata_q;
    end
  end

  // --------------------------------------------------------------------------
  // blend: one channel at a time, horizontal, vertical, then gain
  // --------------------------------------------------------------------------
  function automatic logic [7:0] chan(input logic [31:0] w, input logic [1:0] c);
    return w[8*c +: 8];
  endfunction

  logic [FR_W-1:0]  omc;
  logic [FR_W-1:0]  omr;
  logic [TOP_W-1:0] top_q, bot_q;
  logic [BL_W-1:0]  blend_q;
  logic [GN_W-1:0]  gained;
  logic [GN_W-1:0]  gained_sh;
  logic [7:0]       chan_res;
  logic [7:0]       res_q [4];

  assign omc = FR_W'(ONE) - FR_W'(frac_c_q);
  assign omr = FR_W'(ONE) - FR_W'(frac_r_q);

  always_comb begin
    gained    = GN_W'(blend_q) * GN_W'(gain_q);
    gained_sh = gained >> (2 * FRAC_BITS + 8);
    if (ch_q == 2'd3) begin
      // alpha passes without gain; it cannot exceed 255
      chan_res = blend_q[BL_W-1:2*FRAC_BITS];
    end else if (gained_sh > GN_W'(255)) begin
      chan_res = 8'hFF;
    end else begin
      chan_res = gained_sh[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_H) begin
      top_q <= TOP_W'(chan(pix_q[0], ch_q)) * TOP_W'(omc) +
               TOP_W'(chan(pix_q[1], ch_q)) * TOP_W'(frac_c_q);
      bot_q <= TOP_W'(chan(pix_q[2], ch_q)) * TOP_W'(omc) +
               TOP_W'(chan(pix_q[3], ch_q)) * TOP_W'(frac_c_q);
    end
    if (state_q == ST_V) begin
      blend_q <= BL_W'(top_q) * BL_W'(omr) + BL_W'(bot_q) * BL_W'(frac_r_q);
    end
    if (state_q == ST_G) begin
      res_q[ch_q] <= chan_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (state_q == ST_G) begin
      ch_q <= ch_q + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic     out_valid_q;
  bcs_out_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q.out_col   <= want_col_q;
      out_word_q.out_row   <= want_row_q;
      out_word_q.out_red   <= res_q[0];
      out_word_q.out_green <= res_q[1];
      out_word_q.out_blue  <= res_q[2];
      out_word_q.out_alpha <= res_q[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== src/bcs_checker.sv =====
// ----------------------------------------------------------------------------
// bcs_checker
// port-level checks of the bilinear crop scaler, bound to the top level
// ----------------------------------------------------------------------------
`include "bilinear_crop_scaler_defines.svh"

module bcs_checker import bcs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input bcs_in_t  in_word_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input bcs_out_t out_word_o
);

  logic load_acc;
  logic samp_acc;

  assign load_acc = in_valid_i && !in_stall_o && (in_word_i.cmd == CMD_LOAD);
  assign samp_acc = in_valid_i && !in_stall_o && (in_word_i.cmd == CMD_SAMPLE);

  `BCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled result changed")
  `BCS_ASSERT_NEXT(a_load_single, clk_i, rst_ni, load_acc, !in_stall_o, "load word held the input")
  `BCS_ASSERT_NEXT(a_sample_busy, clk_i, rst_ni, samp_acc, in_stall_o, "sample word not worked alone")
  `BCS_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result with no sample in work")

endmodule

bind bilinear_crop_scaler bcs_checker u_bcs_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bilinear crop scaler: loads rgba pixels, writes
// crop/scale/gain settings over the register port and checks every sampled
// pixel against an in-bench bilinear predictor
// ----------------------------------------------------------------------------
module tb_top;
  import bcs_pkg::*;

  localparam int MAX_W       = 2048;
  localparam int MAX_H       = 1024;
  localparam int FB          = 8;
  localparam int SETTLE      = 120;   // settle time after the last result
  localparam int QUIET_LIMIT = 6000;  // cycles without any accepted word
  localparam int HOLD_LEN    = 1500;  // one long receiver hold-off
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 72;

  // field widths of the registers, in register order
  localparam int REG_BITS [8] = '{12, 11, 10, 12, 11, 12, 11, 10};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  bcs_in_t     in_word_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  bcs_out_t    out_word_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  bilinear_crop_scaler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // register copy, only changed while the block is idle
  int unsigned scale_cfg [8] = '{2048, 0, 0, 1, 1, 1, 1, 256};

  // predictor state, advanced on accepted words
  logic [31:0] image_mem [int];
  int unsigned image_rows = 0;

  // generator view: which pixels the stimulus has already loaded
  bit          loaded_px [int];
  int unsigned loaded_rows = 0;

  bcs_in_t  word_q  [$];   // input words waiting for the driver
  bcs_out_t pixel_q [$];   // predicted result pixels, oldest first

  int  err_cnt   = 0;
  bit  hold_go   = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt  = 0;
  int  stall_left = 0;
  int  gap_left  = 0;
  int  quiet     = 0;
  logic [9:0] cyc_cnt = '0;

  // a quarter of the time neither side adds random gaps or stalls
  wire calm = (cyc_cnt[9:8] == 2'b11);

  function automatic int draw_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  // pixel-centre mapping of one axis: low/high neighbour and 8-bit fraction
  function automatic void scale_axis(input longint unsigned dest, origin, span, size, limit,
                                     output int unsigned lo, hi, frac);
    longint unsigned q, p, ip, low, high;
    if (size == 0) size = 1;
    q    = ((2 * dest + 1) * span * 256) / (2 * size);
    p    = origin * 256 + q + 128;  // position plus one, never negative
    ip   = p >> FB;
    frac = 32'(p & 255);
    low  = (ip == 0) ? 0 : ip - 1;
    if (low > limit - 1) low = limit - 1;
    high = low + 1;
    if (high > limit - 1) high = limit - 1;
    lo = 32'(low);
    hi = 32'(high);
  endfunction

  function automatic void neighbours(input int unsigned wc, wr, rows,
                                     output int unsigned c0, c1, r0, r1, fc, fr);
    int unsigned wu, hu;
    wu = scale_cfg[REG_SOURCE_WIDTH];
    if (wu == 0) wu = 1;
    if (wu > MAX_W) wu = MAX_W;
    hu = rows;
    if (hu == 0) hu = 1;
    if (hu > MAX_H) hu = MAX_H;
    scale_axis(wc, scale_cfg[REG_CROP_LEFT], scale_cfg[REG_CROP_WIDTH],
               scale_cfg[REG_OUT_WIDTH], wu, c0, c1, fc);
    scale_axis(wr, scale_cfg[REG_CROP_TOP], scale_cfg[REG_CROP_HEIGHT],
               scale_cfg[REG_OUT_HEIGHT], hu, r0, r1, fr);
  endfunction

  function automatic logic [31:0] image_at(int unsigned col, row);
    int key;
    key = row * MAX_W + col;
    return image_mem.exists(key) ? image_mem[key] : 32'h0;
  endfunction

  // bilinear blend of the four neighbours, gain on colour only
  function automatic bcs_out_t blend_pixel(bcs_in_t w);
    int unsigned c0, c1, r0, r1, fc, fr;
    logic [31:0] p00, p01, p10, p11;
    longint unsigned top, bot, mix, v;
    logic [7:0] ch [4];
    bcs_out_t o;
    neighbours(w.want_col, w.want_row, image_rows, c0, c1, r0, r1, fc, fr);
    p00 = image_at(c0, r0);
    p01 = image_at(c1, r0);
    p10 = image_at(c0, r1);
    p11 = image_at(c1, r1);
    for (int c = 0; c < 4; c++) begin
      top = longint'(p00[8*c +: 8]) * (256 - fc) + longint'(p01[8*c +: 8]) * fc;
      bot = longint'(p10[8*c +: 8]) * (256 - fc) + longint'(p11[8*c +: 8]) * fc;
      mix = top * (256 - fr) + bot * fr;
      if (c == 3) v = mix >> (2 * FB);
      else v = (mix * scale_cfg[REG_GAIN]) >> (2 * FB + 8);
      if (v > 255) v = 255;
      ch[c] = v[7:0];
    end
    o.out_col   = w.want_col;
    o.out_row   = w.want_row;
    o.out_red   = ch[0];
    o.out_green = ch[1];
    o.out_blue  = ch[2];
    o.out_alpha = ch[3];
    return o;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  function automatic bcs_in_t random_word();
    logic [95:0] raw;
    bcs_in_t w;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(bcs_in_t)-1:0];
    return w;
  endfunction

  task automatic push_load(int unsigned col, row);
    bcs_in_t w;
    w = random_word();
    w.cmd      = CMD_LOAD;
    w.load_col = 11'(col);
    w.load_row = 10'(row);
    word_q.push_back(w);
    loaded_px[row * MAX_W + col] = 1'b1;
    if (row + 1 > loaded_rows) loaded_rows = row + 1;
  endtask

  // never read an unwritten pixel: load any missing neighbour first
  task automatic push_sample(int unsigned wc, wr);
    int unsigned c0, c1, r0, r1, fc, fr;
    bcs_in_t w;
    neighbours(wc, wr, loaded_rows, c0, c1, r0, r1, fc, fr);
    if (!loaded_px.exists(r0 * MAX_W + c0)) push_load(c0, r0);
    if (!loaded_px.exists(r0 * MAX_W + c1)) push_load(c1, r0);
    if (!loaded_px.exists(r1 * MAX_W + c0)) push_load(c0, r1);
    if (!loaded_px.exists(r1 * MAX_W + c1)) push_load(c1, r1);
    w = random_word();
    w.cmd      = CMD_SAMPLE;
    w.want_col = 11'(wc);
    w.want_row = 10'(wr);
    word_q.push_back(w);
  endtask

  // wait for all words taken and all pixels back, then let the block settle
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (word_q.size() != 0 || in_valid_i || pixel_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, int unsigned v);
    int unsigned val;
    val = v & ((1 << REG_BITS[r]) - 1);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scale_cfg[r] = val;
  endtask

  // kind 0: all zero, kind 1: all fields at their top, else mostly small sizes
  task automatic set_phase(int kind);
    int unsigned v;
    for (int i = 0; i < 8; i++) begin
      if (kind == 0) v = 0;
      else if (kind == 1) v = (1 << REG_BITS[i]) - 1;
      else begin
        case (i)
          REG_SOURCE_WIDTH, REG_CROP_WIDTH, REG_CROP_HEIGHT: begin
            case ($urandom_range(0, 9))
              0: v = 0;
              1: v = (1 << REG_BITS[i]) - 1;
              default: v = $urandom_range(1, 12);
            endcase
          end
          REG_OUT_WIDTH, REG_OUT_HEIGHT: begin
            v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 20);
          end
          REG_GAIN: begin
            case ($urandom_range(0, 3))
              0: v = 256;
              1: v = ($urandom_range(0, 1)) ? 0 : 1023;
              default: v = $urandom_range(0, 1023);
            endcase
          end
          default: begin
            v = ($urandom_range(0, 9) == 0) ? (1 << REG_BITS[i]) - 1 : $urandom_range(0, 6);
          end
        endcase
      end
      write_reg(cfg_reg_e'(i), v);
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    int unsigned ow, oh;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    #1;

    // directed: corner pixels, extreme requests, reset settings
    push_load(0, 0);
    push_load(2047, 1023);
    push_load(1, 0);
    push_load(0, 1);
    push_sample(0, 0);
    push_sample(2047, 1023);
    push_sample(1, 1);
    wait_idle();

    // all-zero settings: zero crop, zero output, zero source width, zero gain
    set_phase(0);
    push_sample(0, 0);
    push_sample(2047, 0);
    push_sample(0, 1023);
    wait_idle();

    // every field at its top
    set_phase(1);
    push_sample(0, 0);
    push_sample(2047, 1023);
    push_sample(1024, 512);
    push_sample(4, 3);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_phase(2);
      ow = (scale_cfg[REG_OUT_WIDTH] == 0) ? 1 : scale_cfg[REG_OUT_WIDTH];
      oh = (scale_cfg[REG_OUT_HEIGHT] == 0) ? 1 : scale_cfg[REG_OUT_HEIGHT];
      if (ph == 2) begin
        // a run of samples, with any loads they need, while the receiver holds off
        hold_go = 1'b1;
        for (int k = 0; k < 20; k++)
          push_sample($urandom_range(0, ow - 1), $urandom_range(0, oh - 1));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0: push_load($urandom_range(0, 2047), $urandom_range(0, 1023));
          1, 2: push_load($urandom_range(0, 15), $urandom_range(0, 15));
          3: push_sample($urandom_range(0, 2047), $urandom_range(0, 1023));
          default: push_sample($urandom_range(0, ow - 1), $urandom_range(0, oh - 1));
        endcase
      end
      wait_idle();
    end

    if (pixel_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1'b1;
  end

  // ------------------------------------------------------------------------
  // driver: next word from the queue, random gaps between words
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (gap_left > 0 && !calm) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_word_i  <= word_q.pop_front();
        in_valid_i <= 1'b1;
        gap_left   <= draw_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // receiver stall: random stretches plus one long hold-off
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done   <= 1'b1;
      hold_cnt    <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_stall_i <= (hold_cnt != 1);
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= draw_gap();
    end
  end

  // ------------------------------------------------------------------------
  // monitor: predict on accepted input words, check accepted result words
  // ------------------------------------------------------------------------
  task automatic note_mismatch(string field, int e, int a);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s: expected %0d got %0d", field, e, a);
  endtask

  always @(posedge clk_i) begin
    bcs_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (in_word_i.cmd == CMD_LOAD) begin
          image_mem[in_word_i.load_row * MAX_W + in_word_i.load_col] =
            {in_word_i.in_alpha, in_word_i.in_blue, in_word_i.in_green, in_word_i.in_red};
          if (in_word_i.load_row + 1 > image_rows) image_rows = in_word_i.load_row + 1;
        end else begin
          pixel_q.push_back(blend_pixel(in_word_i));
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          note_mismatch("unexpected word, col", -1, out_word_o.out_col);
        end else begin
          want = pixel_q.pop_front();
          if (out_word_o.out_col !== want.out_col)
            note_mismatch("out_col", want.out_col, out_word_o.out_col);
          if (out_word_o.out_row !== want.out_row)
            note_mismatch("out_row", want.out_row, out_word_o.out_row);
          if (out_word_o.out_red !== want.out_red)
            note_mismatch("out_red", want.out_red, out_word_o.out_red);
          if (out_word_o.out_green !== want.out_green)
            note_mismatch("out_green", want.out_green, out_word_o.out_green);
          if (out_word_o.out_blue !== want.out_blue)
            note_mismatch("out_blue", want.out_blue, out_word_o.out_blue);
          if (out_word_o.out_alpha !== want.out_alpha)
            note_mismatch("out_alpha", want.out_alpha, out_word_o.out_alpha);
        end
      end
    end
  end

  // watchdog: too long without any accepted word on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
